// ----- src/rmf_frame_propagation_defines.svh -----
// Assertion macros for the frame propagation block.
// Used by rmf_frame_propagation; expects clk and rst in scope.
`ifndef RMF_FRAME_PROPAGATION_DEFINES_SVH
`define RMF_FRAME_PROPAGATION_DEFINES_SVH

// same-cycle implication
`define RMF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/rmf_pkg.sv -----
// Shared constants and types for the frame propagation block.
// No dependencies; used by rmf_vec_unit and rmf_frame_propagation.
package rmf_pkg;

  localparam int COORD_WIDTH_DEF   = 32;
  localparam int VEC_FRAC_BITS_DEF = 30;
  localparam int VEC_WIDTH_DEF     = 36;
  localparam int IFRAC             = 30;
  localparam int MUL_BITS          = 32;
  localparam int HELPER_NUM        = 100;
  localparam int HELPER_LIM        = 99;

  typedef enum logic [1:0] {
    VOP_NORM  = 2'd0,
    VOP_REFL  = 2'd1,
    VOP_CROSS = 2'd2
  } vop_t;

  typedef struct packed {
    logic start;
    vop_t op;
  } vcmd_t;

  typedef struct packed {
    logic done;
  } vrsp_t;

endpackage

// ----- src/rmf_vec_unit.sv -----
// Shared vector unit: normalize, reflect across a unit vector, cross product.
// Bit-serial multiplier, square root and divider; uses rmf_pkg.
module rmf_vec_unit #(
  parameter int VW = rmf_pkg::VEC_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rmf_pkg::vcmd_t        cmd,
  input  logic [2:0][VW-1:0]    a,
  input  logic [2:0][VW-1:0]    b,
  output rmf_pkg::vrsp_t        rsp,
  output logic [2:0][VW-1:0]    r
);

  localparam int MBW  = rmf_pkg::MUL_BITS;
  localparam int PW   = VW + MBW;
  localparam int ACCW = PW + 2;
  localparam int SQW  = 2 * MBW;
  localparam int RW   = MBW + 2;
  localparam int QW   = rmf_pkg::IFRAC + 1;
  localparam int DRW  = MBW + 2;
  localparam int BCW  = $clog2(MBW);

  typedef logic [2:0][VW-1:0] vec_t;

  typedef enum logic [12:0] {
    U_IDLE = 13'b0000000000001,
    U_ABS  = 13'b0000000000010,
    U_SHR  = 13'b0000000000100,
    U_SHL  = 13'b0000000001000,
    U_NEXT = 13'b0000000010000,
    U_MUL  = 13'b0000000100000,
    U_ACC  = 13'b0000001000000,
    U_POST = 13'b0000010000000,
    U_SQI  = 13'b0000100000000,
    U_SQRT = 13'b0001000000000,
    U_DIVI = 13'b0010000000000,
    U_DIV  = 13'b0100000000000,
    U_DONE = 13'b1000000000000
  } ust_t;

  ust_t                  st;
  rmf_pkg::vop_t         op_r;
  vec_t                  va, vb, vr;
  logic [2:0]            sg;
  logic [VW-1:0]         m;
  logic [VW-1:0]         ma;
  logic [MBW-1:0]        mb;
  logic [PW-1:0]         prod;
  logic                  neg;
  logic signed [ACCW-1:0] acc;
  logic [VW-1:0]         d;
  logic [1:0]            tc;
  logic [BCW-1:0]        bc;
  logic                  scl;
  logic                  sub;
  logic [SQW-1:0]        sqx;
  logic [RW-1:0]         srem;
  logic [MBW-1:0]        root;
  logic [DRW-1:0]        drem;
  logic [QW-1:0]         q;

  function automatic logic [VW-1:0] absv(input logic [VW-1:0] v);
    return v[VW-1] ? -v : v;
  endfunction

  function automatic logic [VW-1:0] rnd(input logic signed [ACCW-1:0] v);
    logic [ACCW-1:0] mg;
    mg = v[ACCW-1] ? -v : v;
    mg = (mg + (ACCW'(1) << (rmf_pkg::IFRAC - 1))) >> rmf_pkg::IFRAC;
    return VW'(v[ACCW-1] ? -mg : mg);
  endfunction

  function automatic vec_t rot(input vec_t v);
    return {v[0], v[2], v[1]};
  endfunction

  function automatic vec_t push(input vec_t v, input logic [VW-1:0] x);
    return {x, v[2], v[1]};
  endfunction

  logic [VW-1:0]          xa, xb;
  logic                   xinv;
  logic [2:0][VW-1:0]     abs_a;
  logic [VW-1:0]          max01, maxv;
  logic signed [ACCW-1:0] sprod;
  logic [RW-1:0]          rem2, trial;
  logic                   dge;
  logic [DRW-1:0]         dsub;
  logic [QW-1:0]          qf;

  always_comb begin
    xa   = va[0];
    xb   = vb[0];
    xinv = 1'b0;
    case (op_r)
      rmf_pkg::VOP_NORM: begin
        xa = va[0];
        xb = va[0];
      end
      rmf_pkg::VOP_REFL: begin
        xa = scl ? d : va[0];
        xb = vb[0];
      end
      rmf_pkg::VOP_CROSS: begin
        xa   = sub ? va[2] : va[1];
        xb   = sub ? vb[1] : vb[2];
        xinv = sub;
      end
      default: begin
        xa = va[0];
        xb = vb[0];
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) abs_a[i] = absv(va[i]);
    max01 = (abs_a[0] > abs_a[1]) ? abs_a[0] : abs_a[1];
    maxv  = (max01 > abs_a[2]) ? max01 : abs_a[2];
    sprod = signed'({{(ACCW - PW){1'b0}}, prod});
    rem2  = {srem[RW-3:0], sqx[SQW-1:SQW-2]};
    trial = {root, 2'b01};
    dge   = drem >= DRW'(root);
    dsub  = dge ? drem - DRW'(root) : drem;
    qf    = {q[QW-2:0], dge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= U_IDLE;
    end else begin
      case (st)
        U_IDLE: begin
          if (cmd.start) begin
            va   <= a;
            vb   <= b;
            op_r <= cmd.op;
            tc   <= '0;
            acc  <= '0;
            scl  <= 1'b0;
            sub  <= 1'b0;
            st   <= (cmd.op == rmf_pkg::VOP_NORM) ? U_ABS : U_NEXT;
          end
        end
        U_ABS: begin
          va <= abs_a;
          sg <= {va[2][VW-1], va[1][VW-1], va[0][VW-1]};
          m  <= maxv;
          if (maxv == '0) begin
            vr <= '0;
            st <= U_DONE;
          end else begin
            st <= U_SHR;
          end
        end
        U_SHR: begin
          if (m >= (VW'(1) << (rmf_pkg::IFRAC + 1))) begin
            for (int i = 0; i < 3; i++) va[i] <= (va[i] + VW'(1)) >> 1;
            m <= (m + VW'(1)) >> 1;
          end else begin
            st <= U_SHL;
          end
        end
        U_SHL: begin
          if (m < (VW'(1) << rmf_pkg::IFRAC)) begin
            for (int i = 0; i < 3; i++) va[i] <= va[i] << 1;
            m <= m << 1;
          end else begin
            tc  <= '0;
            acc <= '0;
            st  <= U_NEXT;
          end
        end
        U_NEXT: begin
          ma   <= absv(xa);
          mb   <= MBW'(absv(xb));
          neg  <= xa[VW-1] ^ xb[VW-1] ^ xinv;
          prod <= '0;
          bc   <= '0;
          st   <= U_MUL;
        end
        U_MUL: begin
          prod <= {prod[PW-2:0], 1'b0} + (mb[MBW-1] ? PW'(ma) : '0);
          mb   <= {mb[MBW-2:0], 1'b0};
          bc   <= bc + BCW'(1);
          if (bc == BCW'(MBW - 1)) st <= U_ACC;
        end
        U_ACC: begin
          acc <= acc + (neg ? -sprod : sprod);
          st  <= U_POST;
        end
        U_POST: begin
          case (op_r)
            rmf_pkg::VOP_NORM: begin
              va <= rot(va);
              if (tc == 2'd2) begin
                st <= U_SQI;
              end else begin
                tc <= tc + 2'd1;
                st <= U_NEXT;
              end
            end
            rmf_pkg::VOP_REFL: begin
              va <= rot(va);
              vb <= rot(vb);
              if (!scl) begin
                if (tc == 2'd2) begin
                  d   <= rnd(acc);
                  acc <= '0;
                  tc  <= '0;
                  scl <= 1'b1;
                end else begin
                  tc <= tc + 2'd1;
                end
                st <= U_NEXT;
              end else begin
                vr  <= push(vr, va[0] - rnd({acc[ACCW-2:0], 1'b0}));
                acc <= '0;
                if (tc == 2'd2) begin
                  st <= U_DONE;
                end else begin
                  tc <= tc + 2'd1;
                  st <= U_NEXT;
                end
              end
            end
            rmf_pkg::VOP_CROSS: begin
              if (!sub) begin
                sub <= 1'b1;
                st  <= U_NEXT;
              end else begin
                sub <= 1'b0;
                vr  <= push(vr, rnd(acc));
                acc <= '0;
                va  <= rot(va);
                vb  <= rot(vb);
                if (tc == 2'd2) begin
                  st <= U_DONE;
                end else begin
                  tc <= tc + 2'd1;
                  st <= U_NEXT;
                end
              end
            end
            default: st <= U_DONE;
          endcase
        end
        U_SQI: begin
          sqx  <= SQW'(acc);
          srem <= '0;
          root <= '0;
          bc   <= '0;
          st   <= U_SQRT;
        end
        U_SQRT: begin
          if (rem2 >= trial) begin
            srem <= rem2 - trial;
            root <= {root[MBW-2:0], 1'b1};
          end else begin
            srem <= rem2;
            root <= {root[MBW-2:0], 1'b0};
          end
          sqx <= sqx << 2;
          bc  <= bc + BCW'(1);
          if (bc == BCW'(MBW - 1)) begin
            tc <= '0;
            st <= U_DIVI;
          end
        end
        U_DIVI: begin
          drem <= DRW'(va[0]);
          q    <= '0;
          bc   <= '0;
          st   <= U_DIV;
        end
        U_DIV: begin
          drem <= {dsub[DRW-2:0], 1'b0};
          q    <= qf;
          bc   <= bc + BCW'(1);
          if (bc == BCW'(QW - 1)) begin
            vr <= push(vr, sg[0] ? -VW'(qf) : VW'(qf));
            va <= rot(va);
            sg <= {sg[0], sg[2], sg[1]};
            if (tc == 2'd2) begin
              st <= U_DONE;
            end else begin
              tc <= tc + 2'd1;
              st <= U_DIVI;
            end
          end
        end
        U_DONE: st <= U_IDLE;
        default: st <= U_IDLE;
      endcase
    end
  end

  assign rsp.done = (st == U_DONE);
  assign r        = vr;

endmodule

// ----- src/rmf_frame_propagation.sv -----
// Rotation-minimizing frame propagation over a stream of path points. A point
// with no predecessor in its path is taken without a stall and gives no frame.
// Every other point gives one frame (two when it ends the path) and holds the
// input stalled while they are built on the shared vector unit. A propagated
// frame skips the reflections when its chord is zero and the second reflection
// when the tangent difference is zero. The vector unit has a bit-serial
// multiplier, a 32-step square root and a 31-step divider for each component.
// A finished frame waits in the output register while the next one is computed.
// Depends on rmf_pkg, rmf_vec_unit and rmf_frame_propagation_defines.svh.
`include "rmf_frame_propagation_defines.svh"
module rmf_frame_propagation #(
  parameter int COORD_WIDTH   = rmf_pkg::COORD_WIDTH_DEF,
  parameter int VEC_FRAC_BITS = rmf_pkg::VEC_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [COORD_WIDTH-1:0]   pos_x,
  input  logic signed [COORD_WIDTH-1:0]   pos_y,
  input  logic signed [COORD_WIDTH-1:0]   pos_z,
  input  logic                            path_end,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [VEC_FRAC_BITS+1:0] tan_x,
  output logic signed [VEC_FRAC_BITS+1:0] tan_y,
  output logic signed [VEC_FRAC_BITS+1:0] tan_z,
  output logic signed [VEC_FRAC_BITS+1:0] nrm_x,
  output logic signed [VEC_FRAC_BITS+1:0] nrm_y,
  output logic signed [VEC_FRAC_BITS+1:0] nrm_z,
  output logic signed [VEC_FRAC_BITS+1:0] bin_x,
  output logic signed [VEC_FRAC_BITS+1:0] bin_y,
  output logic signed [VEC_FRAC_BITS+1:0] bin_z,
  output logic                            frame_last
);

  localparam int VW   = (COORD_WIDTH + 1 > rmf_pkg::VEC_WIDTH_DEF) ?
                        COORD_WIDTH + 1 : rmf_pkg::VEC_WIDTH_DEF;
  localparam int OW   = VEC_FRAC_BITS + 2;
  localparam int OMW  = VW + 17;
  localparam int SHL  = (VEC_FRAC_BITS >= rmf_pkg::IFRAC) ?
                        VEC_FRAC_BITS - rmf_pkg::IFRAC : 0;
  localparam int SHR  = (VEC_FRAC_BITS < rmf_pkg::IFRAC) ?
                        rmf_pkg::IFRAC - VEC_FRAC_BITS : 0;
  localparam int HALF = (1 << SHR) >> 1;
  localparam int HW   = VW + 7;

  typedef logic [2:0][VW-1:0] vec_t;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_TN   = 11'b00000000010,
    S_HN   = 11'b00000000100,
    S_UN   = 11'b00000001000,
    S_RN   = 11'b00000010000,
    S_RT   = 11'b00000100000,
    S_WN   = 11'b00001000000,
    S_R2   = 11'b00010000000,
    S_NN   = 11'b00100000000,
    S_BX   = 11'b01000000000,
    S_EMIT = 11'b10000000000
  } state_t;

  state_t          state;
  logic [1:0]      ps;
  logic            started;
  logic            init_mode;
  logic            second;
  logic            endf;
  vec_t            inp, pend, old, dv, tv, nv, uv, vv, bv;
  vec_t            ptan, pnrm, pbin;

  rmf_pkg::vcmd_t  cmd;
  rmf_pkg::vrsp_t  rsp;
  vec_t            opa, opb, res;

  vec_t            pin, cv, hv;
  logic [VW-1:0]   ax;
  logic [HW-1:0]   ax100;
  logic            use_y;
  logic            cz, vz;
  logic            in_acc, out_load, run;

  function automatic logic [VW-1:0] sx(input logic [COORD_WIDTH-1:0] v);
    return {{(VW - COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
  endfunction

  function automatic logic [OW-1:0] to_out(input logic [VW-1:0] v);
    logic [OMW-1:0] mg;
    mg = OMW'(v[VW-1] ? -v : v);
    if (VEC_FRAC_BITS >= rmf_pkg::IFRAC) mg = mg << SHL;
    else mg = (mg + OMW'(HALF)) >> SHR;
    mg = v[VW-1] ? -mg : mg;
    return mg[OW-1:0];
  endfunction

  always_comb begin
    pin   = {sx(pos_z), sx(pos_y), sx(pos_x)};
    for (int i = 0; i < 3; i++) cv[i] = pend[i] - old[i];
    ax    = tv[0][VW-1] ? -tv[0] : tv[0];
    ax100 = HW'(ax) * HW'(rmf_pkg::HELPER_NUM);
    use_y = ax100 > (HW'(rmf_pkg::HELPER_LIM) << rmf_pkg::IFRAC);
    hv    = use_y ? {tv[0], VW'(0), -tv[2]} : {-tv[1], tv[2], VW'(0)};
    cz    = (pend == old);
    vz    = (vv == '0);
  end

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state == S_EMIT) && (!out_valid || !out_stall);
  assign run      = (state != S_IDLE) && (state != S_EMIT);

  always_comb begin
    cmd.start = run && !started && !((state == S_WN) && vz);
    cmd.op    = rmf_pkg::VOP_NORM;
    opa       = dv;
    opb       = uv;
    case (state)
      S_TN: opa = dv;
      S_HN: opa = hv;
      S_UN: opa = cv;
      S_RN: begin
        cmd.op = rmf_pkg::VOP_REFL;
        opa    = pnrm;
      end
      S_RT: begin
        cmd.op = rmf_pkg::VOP_REFL;
        opa    = ptan;
      end
      S_WN: opa = vv;
      S_R2: begin
        cmd.op = rmf_pkg::VOP_REFL;
        opa    = nv;
      end
      S_NN: opa = nv;
      S_BX: begin
        cmd.op = rmf_pkg::VOP_CROSS;
        opa    = tv;
        opb    = nv;
      end
      default: opa = dv;
    endcase
  end

  rmf_vec_unit #(.VW(VW)) u_vec (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .a   (opa),
    .b   (opb),
    .rsp (rsp),
    .r   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ps        <= 2'd0;
      started   <= 1'b0;
      out_valid <= 1'b0;
      init_mode <= 1'b0;
      second    <= 1'b0;
      endf      <= 1'b0;
      pend      <= '0;
      old       <= '0;
      ptan      <= '0;
      pnrm      <= '0;
      pbin      <= '0;
    end else begin
      if (cmd.start) started <= 1'b1;
      if (rsp.done) started <= 1'b0;

      if (out_load) begin
        out_valid  <= 1'b1;
        tan_x      <= to_out(tv[0]);
        tan_y      <= to_out(tv[1]);
        tan_z      <= to_out(tv[2]);
        nrm_x      <= to_out(nv[0]);
        nrm_y      <= to_out(nv[1]);
        nrm_z      <= to_out(nv[2]);
        bin_x      <= to_out(bv[0]);
        bin_y      <= to_out(bv[1]);
        bin_z      <= to_out(bv[2]);
        frame_last <= second;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (ps == 2'd0) begin
              pend <= pin;
              ps   <= path_end ? 2'd0 : 2'd1;
            end else begin
              inp <= pin;
              for (int i = 0; i < 3; i++) dv[i] <= pin[i] - pend[i];
              endf      <= path_end;
              init_mode <= (ps == 2'd1);
              second    <= 1'b0;
              state     <= S_TN;
            end
          end
        end
        S_TN: begin
          if (rsp.done) begin
            tv <= res;
            if (init_mode) begin
              state <= S_HN;
            end else if (cz) begin
              nv    <= pnrm;
              bv    <= pbin;
              state <= S_EMIT;
            end else begin
              state <= S_UN;
            end
          end
        end
        S_HN: begin
          if (rsp.done) begin
            nv    <= res;
            state <= S_BX;
          end
        end
        S_UN: begin
          if (rsp.done) begin
            uv    <= res;
            state <= S_RN;
          end
        end
        S_RN: begin
          if (rsp.done) begin
            nv    <= res;
            state <= S_RT;
          end
        end
        S_RT: begin
          if (rsp.done) begin
            for (int i = 0; i < 3; i++) vv[i] <= tv[i] - res[i];
            state <= S_WN;
          end
        end
        S_WN: begin
          if (!started && vz) begin
            state <= S_NN;
          end else if (rsp.done) begin
            uv    <= res;
            state <= S_R2;
          end
        end
        S_R2: begin
          if (rsp.done) begin
            nv    <= res;
            state <= S_NN;
          end
        end
        S_NN: begin
          if (rsp.done) begin
            nv    <= res;
            state <= S_BX;
          end
        end
        S_BX: begin
          if (rsp.done) begin
            bv    <= res;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            ptan <= tv;
            pnrm <= nv;
            pbin <= bv;
            if (!second) begin
              old  <= pend;
              pend <= inp;
              ps   <= 2'd2;
              if (endf) begin
                for (int i = 0; i < 3; i++) dv[i] <= inp[i] - pend[i];
                second    <= 1'b1;
                init_mode <= 1'b0;
                state     <= S_TN;
              end else begin
                state <= S_IDLE;
              end
            end else begin
              ps    <= 2'd0;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RMF_ASSERT_IMPL(a_done_awaited, rsp.done, started, "vector unit finished unrequested")
  `RMF_ASSERT_IMPL(a_ps_saturates, 1'b1, ps != 2'd3, "points count beyond two")
  `RMF_ASSERT_NEXT(a_lone_point, in_acc && (ps == 2'd0), state == S_IDLE, "first point started work")
  `RMF_ASSERT_IMPL(a_end_frame, (state == S_EMIT) && second, endf, "end frame without path end")

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for rmf_frame_propagation: directed path table, then random paths.
// Frames are predicted in fixed point and compared field by field. Depends on the RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int      N_RANDOM  = 2000;
  localparam longint  CYCLE_CAP = 64'd40_000_000;
  localparam int      DRAIN     = 4000;
  localparam int      FRAC      = 30;
  localparam [31:0]   ONE       = 32'h4000_0000;
  localparam [31:0]   NEG_ONE   = 32'hC000_0000;

  typedef struct packed {
    logic [8:0][31:0] comp;
    logic             last;
  } frame_t;

  typedef struct packed {
    logic [31:0] x, y, z;
    logic        fin;
    logic        typed;
    frame_t      want;
  } point_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic        path_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic signed [31:0] tan_x, tan_y, tan_z, nrm_x, nrm_y, nrm_z, bin_x, bin_y, bin_z;
  logic        frame_last;

  rmf_frame_propagation u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .path_end(path_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .tan_x(tan_x), .tan_y(tan_y), .tan_z(tan_z),
    .nrm_x(nrm_x), .nrm_y(nrm_y), .nrm_z(nrm_z),
    .bin_x(bin_x), .bin_y(bin_y), .bin_z(bin_z), .frame_last(frame_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  point_t  points_q[$];
  frame_t  frames_q[$];
  point_t  cur;
  int      errors = 0;
  int      n_points = 0;
  int      n_checked = 0;
  longint  cycles = 0;
  logic    quiet;

  longint older_pt[3], pend_pt[3], last_tan[3], last_nrm[3], last_bin[3];
  int     seen = 0;

  assign quiet = (n_points >= 800) && (n_points < 1100);

  function automatic longint rnd_half(input longint v, input int s);
    longint unsigned mag;
    mag = (v < 0) ? longint'(-v) : v;
    mag = (mag + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned x_in);
    longint unsigned x, r, b;
    x = x_in;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void unit_vec(input longint a[3], output longint u[3]);
    longint unsigned mag[3], m, sq, len;
    m = 0;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (a[i] < 0) ? longint'(-a[i]) : a[i];
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) begin
      u[0] = 0; u[1] = 0; u[2] = 0;
      return;
    end
    while (m >= (64'd1 << 31)) begin
      for (int i = 0; i < 3; i++) mag[i] = (mag[i] + 1) >> 1;
      m = (m + 1) >> 1;
    end
    while (m < (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
      m = m << 1;
    end
    for (int i = 0; i < 3; i++) sq = sq + mag[i] * mag[i];
    len = floor_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      u[i] = longint'((mag[i] << FRAC) / len);
      if (a[i] < 0) u[i] = -u[i];
    end
  endfunction

  function automatic longint dot3(input longint a[3], input longint b[3]);
    return rnd_half(a[0] * b[0] + a[1] * b[1] + a[2] * b[2], FRAC);
  endfunction

  function automatic void cross3(input longint a[3], input longint b[3], output longint r[3]);
    r[0] = rnd_half(a[1] * b[2] - a[2] * b[1], FRAC);
    r[1] = rnd_half(a[2] * b[0] - a[0] * b[2], FRAC);
    r[2] = rnd_half(a[0] * b[1] - a[1] * b[0], FRAC);
  endfunction

  function automatic void mirror(input longint a[3], input longint u[3], output longint r[3]);
    longint d;
    d = dot3(a, u);
    for (int i = 0; i < 3; i++) r[i] = a[i] - rnd_half(2 * d * u[i], FRAC);
  endfunction

  function automatic void seed_frame(input longint tr[3], output longint t[3],
                                     output longint n[3], output longint b[3]);
    longint h[3], ax;
    unit_vec(tr, t);
    ax = (t[0] < 0) ? -t[0] : t[0];
    if (ax * 100 > (longint'(99) << FRAC)) begin
      h[0] = -t[2]; h[1] = 0; h[2] = t[0];
    end else begin
      h[0] = 0; h[1] = t[2]; h[2] = -t[1];
    end
    unit_vec(h, n);
    cross3(t, n, b);
  endfunction

  function automatic void carry_frame(input longint tr[3], output longint t[3],
                                      output longint n[3], output longint b[3]);
    longint c[3], u[3], rn[3], rt[3], v[3], w[3], r2[3];
    unit_vec(tr, t);
    for (int i = 0; i < 3; i++) c[i] = pend_pt[i] - older_pt[i];
    if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
      n = last_nrm;
      b = last_bin;
      return;
    end
    unit_vec(c, u);
    mirror(last_nrm, u, rn);
    mirror(last_tan, u, rt);
    for (int i = 0; i < 3; i++) v[i] = t[i] - rt[i];
    if (v[0] == 0 && v[1] == 0 && v[2] == 0) begin
      r2 = rn;
    end else begin
      unit_vec(v, w);
      mirror(rn, w, r2);
    end
    unit_vec(r2, n);
    cross3(t, n, b);
  endfunction

  function automatic void push_frame(input longint t[3], input longint n[3],
                                     input longint b[3], input logic lst);
    frame_t f;
    for (int i = 0; i < 3; i++) begin
      f.comp[8 - i] = t[i][31:0];
      f.comp[5 - i] = n[i][31:0];
      f.comp[2 - i] = b[i][31:0];
    end
    f.last = lst;
    frames_q.insert(frames_q.size(), f);
    last_tan = t;
    last_nrm = n;
    last_bin = b;
  endfunction

  function automatic void predict_frames(input point_t p);
    longint pt[3], tr[3], t[3], n[3], b[3];
    pt[0] = longint'($signed(p.x));
    pt[1] = longint'($signed(p.y));
    pt[2] = longint'($signed(p.z));
    if (seen == 0) begin
      pend_pt = pt;
      seen = p.fin ? 0 : 1;
      return;
    end
    for (int i = 0; i < 3; i++) tr[i] = pt[i] - pend_pt[i];
    if (seen == 1) seed_frame(tr, t, n, b);
    else carry_frame(tr, t, n, b);
    push_frame(t, n, b, 1'b0);
    if (p.typed) frames_q[$] = p.want;
    older_pt = pend_pt;
    pend_pt = pt;
    seen = 2;
    if (p.fin) begin
      for (int i = 0; i < 3; i++) tr[i] = pend_pt[i] - older_pt[i];
      carry_frame(tr, t, n, b);
      push_frame(t, n, b, 1'b1);
      seen = 0;
    end
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch at frame %0d: %s got %h want %h", n_checked, what, got, want);
  endtask

  function automatic point_t mk(input logic [31:0] x, input logic [31:0] y,
                                input logic [31:0] z, input logic fin);
    point_t p;
    p = '0;
    p.x = x; p.y = y; p.z = z; p.fin = fin;
    return p;
  endfunction

  function automatic point_t mk_typed(input logic [31:0] x, input logic [31:0] y,
                                      input logic [31:0] z, input logic fin,
                                      input logic [8:0][31:0] comp);
    point_t p;
    p = mk(x, y, z, fin);
    p.typed = 1'b1;
    p.want.comp = comp;
    p.want.last = 1'b0;
    return p;
  endfunction

  function automatic logic [31:0] rnd_step();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return $urandom();
      default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  task automatic build_stimulus();
    point_t table_rows[$];
    logic [31:0] bx, by, bz;
    int len;
    table_rows = '{
      mk(32'h0, 32'h0, 32'h0, 1'b0),
      mk_typed(32'h0001_0000, 32'h0, 32'h0, 1'b0,
               {ONE, 32'h0, 32'h0, 32'h0, 32'h0, ONE, 32'h0, NEG_ONE, 32'h0}),
      mk(32'h0002_0000, 32'h0, 32'h0, 1'b0),
      mk(32'h0002_0000, 32'h0001_0000, 32'h0, 1'b0),
      mk(32'h0002_0000, 32'h0001_0000, 32'h0, 1'b0),
      mk(32'h0003_0000, 32'h0001_0000, 32'h0005_0000, 1'b0),
      mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0),
      mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1),
      mk(32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 1'b1),
      mk(32'h0003_0000, 32'h0003_0000, 32'h0003_0000, 1'b0),
      mk_typed(32'h0003_0000, 32'h0003_0000, 32'h0003_0000, 1'b0, '0),
      mk(32'h0003_0000, 32'h0003_0000, 32'h0003_0000, 1'b1),
      mk(32'h0, 32'h0, 32'h0, 1'b0),
      mk(32'h0, 32'h0001_0000, 32'h0, 1'b0),
      mk(32'h0, 32'h0001_0000, 32'h0001_0000, 1'b0),
      mk(32'hFFFF_FFFF, 32'h0001_0000, 32'h0001_0000, 1'b0),
      mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b1),
      mk(32'h0, 32'h0, 32'h0, 1'b0),
      mk(32'h0, 32'h0, 32'h0001, 1'b1)
    };
    foreach (table_rows[i]) points_q.insert(points_q.size(), table_rows[i]);
    while (points_q.size() < N_RANDOM + table_rows.size()) begin
      case ($urandom_range(0, 9))
        0: points_q.insert(points_q.size(), mk($urandom(), $urandom(), $urandom(), 1'b1));
        1: begin
          len = $urandom_range(2, 5);
          for (int k = 0; k < len; k++)
            points_q.insert(points_q.size(),
                            mk($urandom(), $urandom(), $urandom(), k == len - 1));
        end
        default: begin
          len = $urandom_range(2, 12);
          bx = $urandom(); by = $urandom(); bz = $urandom();
          bx = {{4{bx[31]}}, bx[27:0]};
          by = {{4{by[31]}}, by[27:0]};
          bz = {{4{bz[31]}}, bz[27:0]};
          for (int k = 0; k < len; k++) begin
            points_q.insert(points_q.size(), mk(bx, by, bz, k == len - 1));
            bx = bx + rnd_step(); by = by + rnd_step(); bz = bz + rnd_step();
          end
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_frames(cur);
        n_points++;
      end
      if (!in_valid || !in_stall) begin
        if (points_q.size() > 0 && (quiet || $urandom_range(0, 99) >= 8)) begin
          cur = points_q.pop_front();
          pos_x    <= cur.x;
          pos_y    <= cur.y;
          pos_z    <= cur.z;
          path_end <= cur.fin;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    logic [8:0][31:0] got;
    frame_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {tan_x, tan_y, tan_z, nrm_x, nrm_y, nrm_z, bin_x, bin_y, bin_z};
        if (frames_q.size() == 0) begin
          errors++;
          $display("unexpected frame after %0d frames", n_checked);
        end else begin
          want = frames_q.pop_front();
          for (int i = 0; i < 9; i++)
            if (got[8 - i] !== want.comp[8 - i]) report($sformatf("component %0d", i),
                                                        got[8 - i], want.comp[8 - i]);
          if (frame_last !== want.last) report("frame_last", frame_last, want.last);
        end
        n_checked++;
      end
      out_stall <= !quiet && ($urandom_range(0, 99) < 8);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    build_stimulus();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    wait (points_q.size() == 0 && !in_valid && frames_q.size() == 0);
    repeat (DRAIN) @(posedge clk);
    $display("%0d path points sent, %0d frames checked, %0d errors",
             n_points, n_checked, errors);
    $display("covered lone points, zero chords, zero tangents and full-range coordinates");
    if (errors == 0 && frames_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
